[rtl/core/hs3d_pkg.sv]
// Shared types and codes for the 3D heat stencil block.
`default_nettype none
package hs3d_pkg;

    localparam int DATA_W = 32;

    // Item kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_STEP  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_SIZE_X = 3'd0;
    localparam logic [2:0] CFG_SIZE_Y = 3'd1;
    localparam logic [2:0] CFG_SIZE_Z = 3'd2;
    localparam logic [2:0] CFG_SRC_X  = 3'd3;
    localparam logic [2:0] CFG_SRC_Y  = 3'd4;
    localparam logic [2:0] CFG_SRC_Z  = 3'd5;

    // Stencil tap codes, in fetch order
    localparam logic [2:0] TAP_CENTER = 3'd0;
    localparam logic [2:0] TAP_XM     = 3'd1;
    localparam logic [2:0] TAP_XP     = 3'd2;
    localparam logic [2:0] TAP_YM     = 3'd3;
    localparam logic [2:0] TAP_YP     = 3'd4;
    localparam logic [2:0] TAP_ZM     = 3'd5;
    localparam logic [2:0] TAP_ZP     = 3'd6;
    localparam logic [2:0] TAP_LAST   = 3'd7;

    // Controller to datapath commands
    typedef struct packed {
        logic       host_wr;
        logic       host_rd;
        logic       step_init;
        logic       rd_en;
        logic [2:0] rd_sel;
        logic       acc_en;
        logic       acc_first;
        logic       mul_en;
        logic       wr_en;
        logic       next_cell;
        logic       flip;
    } t_cmd;

endpackage
`default_nettype wire

[rtl/core/heat_stencil_3d_step.sv]
// Top level of the 3D heat grid with a 7-point Jacobi time step.
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  command | i_start, o_busy, i_kind, i_cell_index,       | in
//          | i_write_temperature                          |
//  result  | o_valid, o_read_temperature                  | out
//  config  | i_cfg_we, i_cfg_index, i_cfg_data            | in
//
// A command transfers when i_start is high and o_busy is low.
// Cell writes and reads may follow back to back;
// a read result shows on o_valid for one cycle, in the cycle after its transfer.
// A step visits every cell in turn (seven taps through the single bank read
// port, one multiply, one write), with o_busy high until the last cell is written.
// Reset clears the controller and the active bank and sets the sizes to 32 and
// the source to 8,8,8; grid contents are undefined until written. The receiver cannot stall results.
`default_nettype none
module heat_stencil_3d_step #(
    parameter int MAX_EDGE      = 32,
    parameter int FRACTION_BITS = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    output logic               o_busy,
    input  wire  [1:0]         i_kind,
    input  wire  [14:0]        i_cell_index,
    input  wire  signed [31:0] i_write_temperature,
    output logic               o_valid,
    output logic signed [31:0] o_read_temperature,
    input  wire                i_cfg_we,
    input  wire  [2:0]         i_cfg_index,
    input  wire  [5:0]         i_cfg_data
);
    import hs3d_pkg::*;

    t_cmd cmd;
    logic last_cell;

    hs3d_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_kind      (i_kind),
        .i_last_cell (last_cell),
        .o_busy      (o_busy),
        .o_cmd       (cmd)
    );

    hs3d_dpath #(
        .MAX_EDGE      (MAX_EDGE),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .i_cell_index        (i_cell_index),
        .i_write_temperature (i_write_temperature),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_last_cell         (last_cell),
        .o_valid             (o_valid),
        .o_read_temperature  (o_read_temperature)
    );

endmodule
`default_nettype wire

[rtl/core/hs3d_ctrl.sv]
// Sequencer for host transfers and the stencil sweep.
`default_nettype none
module hs3d_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  wire  [1:0]       i_kind,
    input  wire              i_last_cell,
    output logic             o_busy,
    output hs3d_pkg::t_cmd   o_cmd
);
    import hs3d_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_TAP, S_MUL, S_WRITE} t_state;

    t_state     r_state;
    logic [2:0] r_tap;
    logic       accept;

    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    // Command decode
    always_comb begin
        o_cmd           = '0;
        o_cmd.host_wr   = accept && (i_kind == KIND_WRITE);
        o_cmd.host_rd   = accept && (i_kind == KIND_READ);
        o_cmd.step_init = accept && (i_kind == KIND_STEP);
        o_cmd.rd_sel    = r_tap;
        unique case (r_state)
            S_TAP: begin
                o_cmd.rd_en     = (r_tap != TAP_LAST);
                o_cmd.acc_en    = (r_tap != TAP_CENTER);
                o_cmd.acc_first = (r_tap == TAP_XM);
            end
            S_MUL: o_cmd.mul_en = 1'b1;
            S_WRITE: begin
                o_cmd.wr_en     = 1'b1;
                o_cmd.next_cell = !i_last_cell;
                o_cmd.flip      = i_last_cell;
            end
            default: ;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tap   <= TAP_CENTER;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (i_kind == KIND_STEP)) begin
                        r_state <= S_TAP;
                        r_tap   <= TAP_CENTER;
                    end
                end
                S_TAP: begin
                    if (r_tap == TAP_LAST) begin
                        r_state <= S_MUL;
                    end else begin
                        r_tap <= r_tap + 3'd1;
                    end
                end
                S_MUL: r_state <= S_WRITE;
                S_WRITE: begin
                    r_tap   <= TAP_CENTER;
                    r_state <= i_last_cell ? S_IDLE : S_TAP;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

[rtl/core/hs3d_dpath.sv]
// Grid banks, configuration, sweep counters and stencil arithmetic.
`default_nettype none
module hs3d_dpath #(
    parameter int MAX_EDGE      = 32,
    parameter int FRACTION_BITS = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire hs3d_pkg::t_cmd i_cmd,
    input  wire  [14:0]        i_cell_index,
    input  wire  signed [31:0] i_write_temperature,
    input  wire                i_cfg_we,
    input  wire  [2:0]         i_cfg_index,
    input  wire  [5:0]         i_cfg_data,
    output logic               o_last_cell,
    output logic               o_valid,
    output logic signed [31:0] o_read_temperature
);
    import hs3d_pkg::*;

    localparam int CW    = $clog2(MAX_EDGE);
    localparam int AW    = 3 * CW;
    localparam int DEPTH = MAX_EDGE * MAX_EDGE * MAX_EDGE;
    localparam longint CoeffL =
        ((64'd16666 << FRACTION_BITS) + 64'd50000) / 64'd100000;
    localparam int KW = FRACTION_BITS + 1;
    localparam int SW = DATA_W + 3;
    localparam int DW = SW + 1;
    localparam int PW = DW + KW;
    localparam logic signed [KW-1:0] Coeff = KW'(CoeffL);

    // Configuration registers
    logic [5:0] r_size_x, r_size_y, r_size_z;
    logic [4:0] r_src_x, r_src_y, r_src_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= 6'd32;
            r_size_y <= 6'd32;
            r_size_z <= 6'd32;
            r_src_x  <= 5'd8;
            r_src_y  <= 5'd8;
            r_src_z  <= 5'd8;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SIZE_X: r_size_x <= i_cfg_data;
                CFG_SIZE_Y: r_size_y <= i_cfg_data;
                CFG_SIZE_Z: r_size_z <= i_cfg_data;
                CFG_SRC_X:  r_src_x  <= i_cfg_data[4:0];
                CFG_SRC_Y:  r_src_y  <= i_cfg_data[4:0];
                CFG_SRC_Z:  r_src_z  <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Effective sizes: zero acts as one, clamp to the edge limit
    function automatic logic [CW:0] eff_size(input logic [5:0] s);
        logic [CW:0] r;
        if (s == 6'd0) r = (CW+1)'(1);
        else if (32'(s) > MAX_EDGE) r = (CW+1)'(MAX_EDGE);
        else r = (CW+1)'(s);
        return r;
    endfunction

    logic [CW:0]       nx, ny, nz;
    logic [2*CW+1:0]   nxny;
    logic [3*CW+2:0]   total;
    logic              in_grid;
    logic [AW-1:0]     host_addr;

    assign nx        = eff_size(r_size_x);
    assign ny        = eff_size(r_size_y);
    assign nz        = eff_size(r_size_z);
    assign nxny      = nx * ny;
    assign total     = nxny * nz;
    assign in_grid   = 32'(i_cell_index) < 32'(total);
    assign host_addr = AW'(i_cell_index);

    // Sweep counters
    logic [CW-1:0] r_x, r_y, r_z;
    logic [AW-1:0] r_idx;
    logic          r_bank;
    logic          x_end, y_end, z_end;

    assign x_end       = ({1'b0, r_x} + (CW+1)'(1)) == nx;
    assign y_end       = ({1'b0, r_y} + (CW+1)'(1)) == ny;
    assign z_end       = ({1'b0, r_z} + (CW+1)'(1)) == nz;
    assign o_last_cell = x_end && y_end && z_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank <= 1'b0;
            r_x    <= '0;
            r_y    <= '0;
            r_z    <= '0;
            r_idx  <= '0;
        end else begin
            if (i_cmd.flip) r_bank <= !r_bank;
            if (i_cmd.step_init) begin
                r_x   <= '0;
                r_y   <= '0;
                r_z   <= '0;
                r_idx <= '0;
            end else if (i_cmd.next_cell) begin
                r_idx <= r_idx + AW'(1);
                if (x_end) begin
                    r_x <= '0;
                    if (y_end) begin
                        r_y <= '0;
                        r_z <= r_z + CW'(1);
                    end else begin
                        r_y <= r_y + CW'(1);
                    end
                end else begin
                    r_x <= r_x + CW'(1);
                end
            end
        end
    end

    // Tap address; a neighbor beyond a face reads the cell itself
    logic [AW-1:0] step_addr;
    logic [AW-1:0] stride_y, stride_z;

    assign stride_y = AW'(nx);
    assign stride_z = AW'(nxny);

    always_comb begin
        unique case (i_cmd.rd_sel)
            TAP_XM: step_addr = (r_x != '0) ? r_idx - AW'(1) : r_idx;
            TAP_XP: step_addr = !x_end ? r_idx + AW'(1) : r_idx;
            TAP_YM: step_addr = (r_y != '0) ? r_idx - stride_y : r_idx;
            TAP_YP: step_addr = !y_end ? r_idx + stride_y : r_idx;
            TAP_ZM: step_addr = (r_z != '0) ? r_idx - stride_z : r_idx;
            TAP_ZP: step_addr = !z_end ? r_idx + stride_z : r_idx;
            default: step_addr = r_idx;
        endcase
    end

    // Grid banks: one write and one registered read each per cycle
    logic [DATA_W-1:0] bank0 [DEPTH];
    logic [DATA_W-1:0] bank1 [DEPTH];
    logic [DATA_W-1:0] r_rd0, r_rd1;
    logic [AW-1:0]     raddr, waddr;
    logic [DATA_W-1:0] wdata, new_val;
    logic              we0, we1;
    logic signed [DATA_W-1:0] rdata;

    assign raddr = i_cmd.rd_en ? step_addr : host_addr;
    assign waddr = i_cmd.wr_en ? r_idx : host_addr;
    assign wdata = i_cmd.wr_en ? new_val : i_write_temperature;
    assign we0   = (i_cmd.host_wr && in_grid && !r_bank) || (i_cmd.wr_en && r_bank);
    assign we1   = (i_cmd.host_wr && in_grid && r_bank) || (i_cmd.wr_en && !r_bank);
    assign rdata = r_bank ? r_rd1 : r_rd0;

    always_ff @(posedge i_clk) begin
        if (we0) bank0[waddr] <= wdata;
        r_rd0 <= bank0[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (we1) bank1[waddr] <= wdata;
        r_rd1 <= bank1[raddr];
    end

    // Host read result, valid in the cycle after transfer
    logic r_rd_q, r_in_grid_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_q <= 1'b0;
        end else begin
            r_rd_q <= i_cmd.host_rd;
        end
        r_in_grid_q <= in_grid;
    end

    assign o_valid            = r_rd_q;
    assign o_read_temperature = r_in_grid_q ? rdata : '0;

    // Accumulate taps, then multiply, then shift, add and saturate; the source cell keeps its value
    logic signed [DATA_W-1:0] r_tc;
    logic signed [SW-1:0]     r_sum;
    logic signed [PW-1:0]     r_prod;
    logic signed [DW-1:0]     diff;
    logic signed [PW-1:0]     shifted, sum_new;
    logic                     fits, is_src;

    assign diff = DW'(r_sum) - (DW'(r_tc) * DW'(6));

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_en) begin
            if (i_cmd.acc_first) begin
                r_tc  <= rdata;
                r_sum <= '0;
            end else begin
                r_sum <= r_sum + SW'(rdata);
            end
        end
        if (i_cmd.mul_en) r_prod <= PW'(diff) * PW'(Coeff);
    end

    assign shifted = r_prod >>> FRACTION_BITS;
    assign sum_new = shifted + PW'(r_tc);
    assign fits    = (sum_new[PW-1:DATA_W-1] == '0) || (sum_new[PW-1:DATA_W-1] == '1);
    assign is_src  = (32'(r_x) == 32'(r_src_x)) && (32'(r_y) == 32'(r_src_y))
                  && (32'(r_z) == 32'(r_src_z));

    always_comb begin
        priority if (is_src) new_val = r_tc;
        else if (fits) new_val = sum_new[DATA_W-1:0];
        else if (sum_new[PW-1]) new_val = {1'b1, {(DATA_W-1){1'b0}}};
        else new_val = {1'b0, {(DATA_W-1){1'b1}}};
    end

endmodule
`default_nettype wire
